// ----- design/fct_pkg.sv -----
// Shared constants and types for the frustum cull test block.
// Holds the configuration register map, the plane and vector layouts and the op codes.
// No dependencies.
package fct_pkg;

    localparam int FIELD_W    = 16;
    localparam int FRAC_BITS  = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int VIEW_W     = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HIGH = 3'd7;

    localparam logic OP_BOX    = 1'b0;
    localparam logic OP_SPHERE = 1'b1;

    typedef struct packed {
        logic signed [FIELD_W-1:0] d;
        logic signed [FIELD_W-1:0] c;
        logic signed [FIELD_W-1:0] b;
        logic signed [FIELD_W-1:0] a;
    } plane_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] z;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] x;
    } vec3_t;

    localparam vec3_t VIEW_LOW_RESET  = 48'h8000_8000_8000;
    localparam vec3_t VIEW_HIGH_RESET = 48'h7FFF_7FFF_7FFF;

endpackage

// ----- design/frustum_cull_test.sv -----
// Frustum cull test: box and sphere visibility tests against configured clip planes.
// Four-stage pipeline with valid/ready handshakes on input and output.
// Depends on fct_pkg for the register map, plane layout and op codes.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+----------------------------------------------
//  input    | in_valid / in_ready    | op, box_min_*, box_max_*, sphere_*, radius
//  output   | out_valid / out_ready  | culled
//  config   | cfg_we (no wait)       | cfg_addr, cfg_wdata
//
// The block takes one transaction per cycle while the output side does not stall.
// Each transaction passes through the stages in order: input register, coefficient
// multipliers, per-axis maximum, plane sum and sign test.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the register defaults.
// A stall at the output backs up stage by stage; every stage holds its transaction
// until the next stage frees, so nothing is lost or repeated.
module frustum_cull_test
    import fct_pkg::*;
#(
    parameter int PLANE_COUNT = 6,
    parameter int COORD_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_we,
    input  logic [CFG_IDX_W-1:0]           cfg_addr,
    input  logic [CFG_DATA_W-1:0]          cfg_wdata,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic signed [COORD_BITS-1:0]   box_min_x,
    input  logic signed [COORD_BITS-1:0]   box_min_y,
    input  logic signed [COORD_BITS-1:0]   box_min_z,
    input  logic signed [COORD_BITS-1:0]   box_max_x,
    input  logic signed [COORD_BITS-1:0]   box_max_y,
    input  logic signed [COORD_BITS-1:0]   box_max_z,
    input  logic signed [COORD_BITS-1:0]   sphere_x,
    input  logic signed [COORD_BITS-1:0]   sphere_y,
    input  logic signed [COORD_BITS-1:0]   sphere_z,
    input  logic [COORD_BITS-2:0]          sphere_radius,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           culled
);

    // Product of a Q1.14 coefficient and a coordinate.
    localparam int PW = FIELD_W + COORD_BITS;
    // Sum of three products, the offset term and the radius term, plus sign headroom.
    localparam int SW = ((PW > FIELD_W + FRAC_BITS) ? PW : (FIELD_W + FRAC_BITS)) + 2;
    // Common width for the camera box compare.
    localparam int XW = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

    // ------------------------------------------------------------------
    // Configuration registers. Only the planes that are tested are kept.
    // ------------------------------------------------------------------
    plane_t plane_reg [PLANE_COUNT];
    vec3_t  view_low_reg;
    vec3_t  view_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                plane_reg[p] <= '0;
            end
            view_low_reg  <= VIEW_LOW_RESET;
            view_high_reg <= VIEW_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_VIEW_LOW:  view_low_reg  <= vec3_t'(cfg_wdata[VIEW_W-1:0]);
                CFG_VIEW_HIGH: view_high_reg <= vec3_t'(cfg_wdata[VIEW_W-1:0]);
                default:
                begin
                    for (int p = 0; p < PLANE_COUNT; p++)
                    begin
                        if (cfg_addr == CFG_IDX_W'(p))
                        begin
                            plane_reg[p] <= plane_t'(cfg_wdata);
                        end
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage control. A stage loads whenever it is empty or the stage after
    // it is loading too.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the request is reduced to a low and high corner per axis.
    // A sphere uses its center for both, so the per-axis maximum in stage 3
    // gives the plane value at the center. The highest plane value over the
    // eight box corners is the sum of the per-axis maxima, so one sign test
    // per plane covers all corners. The camera box test is done here.
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] in_lo [3];
    logic signed [COORD_BITS-1:0] in_hi [3];
    logic signed [FIELD_W-1:0]    view_lo [3];
    logic signed [FIELD_W-1:0]    view_hi [3];
    logic                         in_miss;
    logic                         is_sphere;

    assign is_sphere = (op == OP_SPHERE);
    assign in_lo[0]  = is_sphere ? sphere_x : box_min_x;
    assign in_lo[1]  = is_sphere ? sphere_y : box_min_y;
    assign in_lo[2]  = is_sphere ? sphere_z : box_min_z;
    assign in_hi[0]  = is_sphere ? sphere_x : box_max_x;
    assign in_hi[1]  = is_sphere ? sphere_y : box_max_y;
    assign in_hi[2]  = is_sphere ? sphere_z : box_max_z;
    assign view_lo[0] = view_low_reg.x;
    assign view_lo[1] = view_low_reg.y;
    assign view_lo[2] = view_low_reg.z;
    assign view_hi[0] = view_high_reg.x;
    assign view_hi[1] = view_high_reg.y;
    assign view_hi[2] = view_high_reg.z;

    always_comb
    begin
        in_miss = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            if ((XW'(view_lo[a]) > XW'(in_hi[a])) || (XW'(view_hi[a]) < XW'(in_lo[a])))
            begin
                in_miss = 1'b1;
            end
        end
        in_miss = in_miss && (op == OP_BOX);
    end

    logic signed [COORD_BITS-1:0] s1_lo_reg [3];
    logic signed [COORD_BITS-1:0] s1_hi_reg [3];
    logic [COORD_BITS-2:0]        s1_bias_reg;
    logic                         s1_miss_reg;

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_lo_reg   <= in_lo;
            s1_hi_reg   <= in_hi;
            s1_bias_reg <= is_sphere ? sphere_radius : '0;
            s1_miss_reg <= in_miss;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: coefficient times coordinate, both corners, every plane.
    // ------------------------------------------------------------------
    logic signed [PW-1:0]  s2_plo_reg [PLANE_COUNT][3];
    logic signed [PW-1:0]  s2_phi_reg [PLANE_COUNT][3];
    logic [COORD_BITS-2:0] s2_bias_reg;
    logic                  s2_miss_reg;
    logic signed [FIELD_W-1:0] coef [PLANE_COUNT][3];

    always_comb
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            coef[p][0] = plane_reg[p].a;
            coef[p][1] = plane_reg[p].b;
            coef[p][2] = plane_reg[p].c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    s2_plo_reg[p][a] <= PW'(coef[p][a]) * PW'(s1_lo_reg[a]);
                    s2_phi_reg[p][a] <= PW'(coef[p][a]) * PW'(s1_hi_reg[a]);
                end
            end
            s2_bias_reg <= s1_bias_reg;
            s2_miss_reg <= s1_miss_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the larger product on each axis.
    // ------------------------------------------------------------------
    logic signed [PW-1:0]  s3_max_reg [PLANE_COUNT][3];
    logic [COORD_BITS-2:0] s3_bias_reg;
    logic                  s3_miss_reg;

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    s3_max_reg[p][a] <= (s2_phi_reg[p][a] > s2_plo_reg[p][a]) ?
                                        s2_phi_reg[p][a] : s2_plo_reg[p][a];
                end
            end
            s3_bias_reg <= s2_bias_reg;
            s3_miss_reg <= s2_miss_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: plane value plus the scaled radius; a negative total or a camera box miss culls.
    // For a box the radius term is zero.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] bias_term;
    logic signed [SW-1:0] plane_sum [PLANE_COUNT];
    logic                 any_neg;
    logic                 s4_culled_reg;

    assign bias_term = SW'(signed'({1'b0, s3_bias_reg, {FRAC_BITS{1'b0}}}));

    always_comb
    begin
        any_neg = 1'b0;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            plane_sum[p] = SW'(s3_max_reg[p][0]) + SW'(s3_max_reg[p][1])
                         + SW'(s3_max_reg[p][2])
                         + (SW'(plane_reg[p].d) <<< FRAC_BITS) + bias_term;
            any_neg = any_neg || plane_sum[p][SW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready)
        begin
            s4_culled_reg <= s3_miss_reg || any_neg;
        end
    end

    assign out_valid = s4_valid_reg;
    assign culled    = s4_culled_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    logic [3:0] occupancy;
    assign occupancy = {s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg};

    // An accepted transaction with no delivery adds exactly one to the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !(out_valid && out_ready))
        |=> ($countones(occupancy) == $past($countones(occupancy)) + 1))
    else $error("pipeline occupancy did not grow by one on accept");

    // A free output lets the whole pipeline advance.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
    else $error("input stalled although output is ready");

    // Stage 1, when blocked by stage 2, keeps its transaction and its miss and bias payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready)
        |=> (s1_valid_reg && $stable(s1_miss_reg) && $stable(s1_bias_reg)))
    else $error("stalled stage 1 transaction changed");

endmodule
